// ----- hw/rtl/chunk_datagram_deframer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// chunk datagram deframer assertion macros
// shared concurrent assertion forms, clocked on clock, quiet in reset
// ----------------------------------------------------------------------------
`ifndef CHUNK_DATAGRAM_DEFRAMER_UNIT_ASSERT_SVH
`define CHUNK_DATAGRAM_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define CDD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/cdd_pkg.sv -----
// ----------------------------------------------------------------------------
// cdd_pkg
// shared types and codes of the chunk datagram deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

   // result kinds
   localparam logic [1:0] KIND_CHUNK  = 2'd0;
   localparam logic [1:0] KIND_SENDER = 2'd1;
   localparam logic [1:0] KIND_NAME   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_START = 2'd1;
   localparam logic [1:0] STATUS_BAD_END   = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // framing markers
   localparam logic [7:0] MARK_START    = 8'h01;
   localparam logic [7:0] MARK_END      = 8'h03;
   localparam logic [1:0] MARKER_LENGTH = 2'd3;

   // result queue depth, a power of two of at least two
   localparam int QUEUE_DEPTH = 4;

   // one result item without its position
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [1:0]  status;
      logic [31:0] message_size;
      logic [31:0] file_id;
      logic [31:0] total_size;
      logic [31:0] chunk_length;
      logic [31:0] chunk_offset;
      logic [31:0] source_size;
      logic        last_result;
   } cdd_result_type;

   // results pushed in one cycle
   typedef struct packed {
      logic first;
      logic second;
   } cdd_push_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cdd_parser.sv -----
// ----------------------------------------------------------------------------
// cdd_parser
// per-byte phase tracking, header collection and result building
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chunk_datagram_deframer_unit_assert.svh"

module cdd_parser import cdd_pkg::*; #(
   parameter int POSITION_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      take,
   input  wire logic [7:0]                in_byte,
   input  wire logic                      end_of_datagram,
   output cdd_push_type                   push,
   output cdd_result_type                 first_result,
   output logic [POSITION_WIDTH-1:0]      first_position,
   output cdd_result_type                 second_result
);

   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_MSIZE  = 4'd1;
   localparam logic [3:0] PH_SLEN   = 4'd2;
   localparam logic [3:0] PH_SENDER = 4'd3;
   localparam logic [3:0] PH_FID    = 4'd4;
   localparam logic [3:0] PH_TOTAL  = 4'd5;
   localparam logic [3:0] PH_NLEN   = 4'd6;
   localparam logic [3:0] PH_NAME   = 4'd7;
   localparam logic [3:0] PH_CLEN   = 4'd8;
   localparam logic [3:0] PH_COFF   = 4'd9;
   localparam logic [3:0] PH_CHUNK  = 4'd10;
   localparam logic [3:0] PH_SRC    = 4'd11;
   localparam logic [3:0] PH_END    = 4'd12;
   localparam logic [3:0] PH_DONE   = 4'd13;
   localparam logic [3:0] PH_SKIP   = 4'd14;

   logic [3:0]  phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  sender_len_ff, sender_len_in;
   logic [7:0]  name_len_ff, name_len_in;
   logic [31:0] msize_ff, msize_in;
   logic [31:0] fid_ff, fid_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] clen_ff, clen_in;
   logic [31:0] coff_ff, coff_in;
   logic [31:0] src_ff, src_in;
   logic [1:0]  error_ff, error_in;

   logic [31:0] count_inc;
   logic [31:0] byte_shifted;
   logic [31:0] word_value;
   logic        word_done;
   logic [31:0] stream_len;
   logic        stream_done;
   logic        is_stream;
   logic [1:0]  stream_kind;
   logic [1:0]  status_code;
   logic        eod_take;
   cdd_result_type stream_rec;
   cdd_result_type status_rec;

   assign count_inc = count_ff + 32'd1;

   // little-endian byte lane of the word being collected
   always_comb begin
      case (count_ff[1:0])
         2'd0:    byte_shifted = {24'd0, in_byte};
         2'd1:    byte_shifted = {16'd0, in_byte, 8'd0};
         2'd2:    byte_shifted = {8'd0, in_byte, 16'd0};
         2'd3:    byte_shifted = {in_byte, 24'd0};
         default: byte_shifted = 32'd0;
      endcase
   end

   assign word_value = acc_ff | byte_shifted;
   assign word_done  = (count_ff[1:0] == 2'd3);

   always_comb begin
      case (phase_ff)
         PH_SENDER: stream_len = {24'd0, sender_len_ff};
         PH_NAME:   stream_len = {24'd0, name_len_ff};
         default:   stream_len = clen_ff;
      endcase
   end

   assign stream_done = (count_inc == stream_len);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      sender_len_in = sender_len_ff;
      name_len_in   = name_len_ff;
      msize_in      = msize_ff;
      fid_in        = fid_ff;
      total_in      = total_ff;
      clen_in       = clen_ff;
      coff_in       = coff_ff;
      src_in        = src_ff;
      error_in      = error_ff;
      is_stream     = 1'b0;
      stream_kind   = KIND_CHUNK;
      status_code   = STATUS_OK;
      eod_take      = take && end_of_datagram;

      case (phase_ff)
         PH_START: begin
            if (in_byte != MARK_START) begin
               error_in = STATUS_BAD_START;
               phase_in = PH_SKIP;
            end else if (count_inc[1:0] == MARKER_LENGTH) begin
               count_in = 32'd0;
               phase_in = PH_MSIZE;
            end else begin
               count_in = count_inc;
            end
         end
         PH_MSIZE, PH_FID, PH_TOTAL, PH_CLEN, PH_COFF, PH_SRC: begin
            count_in = {30'd0, count_inc[1:0]};
            acc_in   = word_done ? 32'd0 : word_value;
            if (word_done) begin
               case (phase_ff)
                  PH_MSIZE: begin
                     msize_in = word_value;
                     phase_in = PH_SLEN;
                  end
                  PH_FID: begin
                     fid_in   = word_value;
                     phase_in = PH_TOTAL;
                  end
                  PH_TOTAL: begin
                     total_in = word_value;
                     phase_in = PH_NLEN;
                  end
                  PH_CLEN: begin
                     clen_in  = word_value;
                     phase_in = PH_COFF;
                  end
                  PH_COFF: begin
                     coff_in  = word_value;
                     phase_in = (clen_ff != 32'd0) ? PH_CHUNK : PH_SRC;
                  end
                  default: begin
                     src_in   = word_value;
                     phase_in = PH_END;
                  end
               endcase
            end
         end
         PH_SLEN: begin
            sender_len_in = in_byte;
            count_in      = 32'd0;
            phase_in      = (in_byte != 8'd0) ? PH_SENDER : PH_FID;
         end
         PH_NLEN: begin
            name_len_in = in_byte;
            count_in    = 32'd0;
            phase_in    = (in_byte != 8'd0) ? PH_NAME : PH_CLEN;
         end
         PH_SENDER, PH_NAME, PH_CHUNK: begin
            is_stream = 1'b1;
            count_in  = stream_done ? 32'd0 : count_inc;
            case (phase_ff)
               PH_SENDER: begin
                  stream_kind = KIND_SENDER;
                  if (stream_done) phase_in = PH_FID;
               end
               PH_NAME: begin
                  stream_kind = KIND_NAME;
                  if (stream_done) phase_in = PH_CLEN;
               end
               default: begin
                  stream_kind = KIND_CHUNK;
                  if (stream_done) phase_in = PH_SRC;
               end
            endcase
         end
         PH_END: begin
            if (in_byte != MARK_END && error_ff == STATUS_OK) error_in = STATUS_BAD_END;
            if (count_inc[1:0] == MARKER_LENGTH) begin
               count_in = 32'd0;
               phase_in = PH_DONE;
            end else begin
               count_in = count_inc;
            end
         end
         default: begin
            // done or skipping: bytes ignored
         end
      endcase

      // status reflects the state after this byte
      if (error_in != STATUS_OK) status_code = error_in;
      else if (phase_in != PH_DONE) status_code = STATUS_TRUNCATED;
      else status_code = STATUS_OK;

      status_rec              = '0;
      status_rec.kind         = KIND_STATUS;
      status_rec.status       = status_code;
      status_rec.message_size = msize_in;
      status_rec.file_id      = fid_in;
      status_rec.total_size   = total_in;
      status_rec.chunk_length = clen_in;
      status_rec.chunk_offset = coff_in;
      status_rec.source_size  = src_in;
      status_rec.last_result  = 1'b1;

      stream_rec            = '0;
      stream_rec.kind       = stream_kind;
      stream_rec.byte_value = in_byte;

      // each datagram is parsed afresh
      if (end_of_datagram) begin
         phase_in      = PH_START;
         count_in      = 32'd0;
         acc_in        = 32'd0;
         sender_len_in = 8'd0;
         name_len_in   = 8'd0;
         msize_in      = 32'd0;
         fid_in        = 32'd0;
         total_in      = 32'd0;
         clen_in       = 32'd0;
         coff_in       = 32'd0;
         src_in        = 32'd0;
         error_in      = STATUS_OK;
      end

      push.first     = take && (is_stream || end_of_datagram);
      push.second    = eod_take && is_stream;
      first_result   = is_stream ? stream_rec : status_rec;
      first_position = is_stream ? count_ff[POSITION_WIDTH-1:0] : '0;
      second_result  = status_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         count_ff      <= 32'd0;
         acc_ff        <= 32'd0;
         sender_len_ff <= 8'd0;
         name_len_ff   <= 8'd0;
         msize_ff      <= 32'd0;
         fid_ff        <= 32'd0;
         total_ff      <= 32'd0;
         clen_ff       <= 32'd0;
         coff_ff       <= 32'd0;
         src_ff        <= 32'd0;
         error_ff      <= STATUS_OK;
      end else if (take) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         acc_ff        <= acc_in;
         sender_len_ff <= sender_len_in;
         name_len_ff   <= name_len_in;
         msize_ff      <= msize_in;
         fid_ff        <= fid_in;
         total_ff      <= total_in;
         clen_ff       <= clen_in;
         coff_ff       <= coff_in;
         src_ff        <= src_in;
         error_ff      <= error_in;
      end
   end

   `CDD_ASSERT_NEXT(a_fresh_after_status, eod_take, phase_ff == PH_START && error_ff == STATUS_OK, "parser not cleared after status record")
   `CDD_ASSERT_SAME(a_stream_phase, push.first && is_stream, phase_ff == PH_SENDER || phase_ff == PH_NAME || phase_ff == PH_CHUNK, "streamed byte outside a byte field")
   `CDD_ASSERT_SAME(a_second_is_status, push.second, end_of_datagram && push.first, "second result without end of datagram")

endmodule

`default_nettype wire

// ----- hw/rtl/cdd_result_queue.sv -----
// ----------------------------------------------------------------------------
// cdd_result_queue
// small result queue taking up to two entries and giving one per cycle while out_stall is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chunk_datagram_deframer_unit_assert.svh"

module cdd_result_queue import cdd_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cdd_push_type     push,
   input  wire logic [WIDTH-1:0] first_data,
   input  wire logic [WIDTH-1:0] second_data,
   output logic                  has_room,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] data_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic [CNT_W-1:0] push_count;
   logic             pop;

   assign wr_next    = wr_ptr_ff + PTR_W'(1);
   assign push_count = CNT_W'(push.first) + CNT_W'(push.second);
   assign out_valid  = (count_ff != '0);
   assign pop        = out_valid && !out_stall;
   assign has_room   = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign out_data   = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + push_count - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) data_ff[wr_ptr_ff] <= first_data;
      if (push.second) data_ff[wr_next] <= second_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CDD_ASSERT_SAME(a_no_overflow, push_count != '0, count_ff <= CNT_W'(QUEUE_DEPTH) - push_count + CNT_W'(pop), "result queue overflow")
   `CDD_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "result queue count out of range")
   `CDD_ASSERT_NEXT(a_pop_only, pop && push_count == '0, count_ff == $past(count_ff) - CNT_W'(1), "result queue count lost a pop")

endmodule

`default_nettype wire

// ----- hw/rtl/chunk_datagram_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// chunk_datagram_deframer_unit
// parses chunk datagrams one byte per transfer, streams sender, name and chunk
// bytes and closes each datagram with a status record of its word-sized fields
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_stall  | in_byte, end_of_datagram
//   rsp     | out       | rsp_valid/rsp_stall  | kind, byte_value, position,
//           |           |                      | status, header fields, last
//
// one byte transfer per cycle while req_stall is low; its results go into
// a four-entry queue the next cycle, in the order they were given
// a byte with end_of_datagram may give two results (streamed byte, status);
// the queue sends them one at a time, one per cycle while rsp_stall is low
// req_stall rises when fewer than two queue entries are free; it comes from
// a register only and never from rsp_stall directly
// synchronous reset returns the parser to waiting for a start marker and
// empties the queue; no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chunk_datagram_deframer_unit import cdd_pkg::*; #(
   parameter int POSITION_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // byte input
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,
   input  wire logic                      req_end_of_datagram,
   // results
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_byte_value,
   output logic [POSITION_WIDTH-1:0]      rsp_byte_position,
   output logic [1:0]                     rsp_status,
   output logic [31:0]                    rsp_message_size,
   output logic [31:0]                    rsp_file_id,
   output logic [31:0]                    rsp_total_size,
   output logic [31:0]                    rsp_chunk_length,
   output logic [31:0]                    rsp_chunk_offset,
   output logic [31:0]                    rsp_source_size,
   output logic                           rsp_last_result
);

   // queue entry: position on top of the result record
   localparam int REC_W   = $bits(cdd_result_type);
   localparam int ENTRY_W = POSITION_WIDTH + REC_W;

   logic                      take;
   logic                      has_room;
   cdd_push_type              push;
   cdd_result_type            first_result;
   cdd_result_type            second_result;
   logic [POSITION_WIDTH-1:0] first_position;
   logic [ENTRY_W-1:0]        head;
   cdd_result_type            head_rec;

   // a byte transfer happens only with room for both possible results
   assign req_stall = !has_room;
   assign take      = req_valid && !req_stall;

   cdd_parser #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .in_byte         (req_in_byte),
      .end_of_datagram (req_end_of_datagram),
      .push            (push),
      .first_result    (first_result),
      .first_position  (first_position),
      .second_result   (second_result)
   );

   // the status record always carries position zero
   cdd_result_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_data  ({first_position, first_result}),
      .second_data ({{POSITION_WIDTH{1'b0}}, second_result}),
      .has_room    (has_room),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_data    (head)
   );

   // unpack the head entry onto the result ports
   assign head_rec          = cdd_result_type'(head[REC_W-1:0]);
   assign rsp_byte_position = head[ENTRY_W-1 -: POSITION_WIDTH];
   assign rsp_kind          = head_rec.kind;
   assign rsp_byte_value    = head_rec.byte_value;
   assign rsp_status        = head_rec.status;
   assign rsp_message_size  = head_rec.message_size;
   assign rsp_file_id       = head_rec.file_id;
   assign rsp_total_size    = head_rec.total_size;
   assign rsp_chunk_length  = head_rec.chunk_length;
   assign rsp_chunk_offset  = head_rec.chunk_offset;
   assign rsp_source_size   = head_rec.source_size;
   assign rsp_last_result   = head_rec.last_result;

endmodule

`default_nettype wire
